FILE: sv/srs_pkg.sv
// Shared types, constants and helpers for the sensor reading statistics unit.
// Used by srs_div, srs_datapath, srs_ctrl and the top level; no dependencies.
package srs_pkg;

  // Counter sizing
  localparam int MaxReadings = 1024;
  localparam int CountW      = 11;
  localparam int ValueW      = 15;
  localparam int ReadingW    = 16;
  localparam int SumW        = 26;
  localparam int CfgIdxW     = 2;
  localparam int BandNum     = 4;
  localparam int BandW       = 2;

  // Every count stops here
  localparam logic [CountW-1:0] CountCap =
    CountW'((MaxReadings < 2047) ? MaxReadings : 2047);

  // Divider: one quotient bit per step
  localparam int DivSteps = SumW;
  localparam int StepW    = $clog2(DivSteps);

  // Register indexes on the config port
  localparam logic [CfgIdxW-1:0] RegWarning  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegCritical = 2'd1;
  localparam logic [CfgIdxW-1:0] RegShutdown = 2'd2;

  // Register reset values
  localparam logic [ValueW-1:0] WarningReset  = 15'd300;
  localparam logic [ValueW-1:0] CriticalReset = 15'd450;
  localparam logic [ValueW-1:0] ShutdownReset = 15'd600;

  // Band codes
  localparam logic [BandW-1:0] BandNormal   = 2'd0;
  localparam logic [BandW-1:0] BandWarning  = 2'd1;
  localparam logic [BandW-1:0] BandCritical = 2'd2;
  localparam logic [BandW-1:0] BandShutdown = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic item_accept;
    logic close_set;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;
  } status_t;

  // Saturating increment of a count
  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] c);
    sat_inc = (c < CountCap) ? c + CountW'(1) : CountCap;
  endfunction

endpackage

FILE: sv/srs_div.sv
// Restoring divider, one quotient bit per cycle, for the set average.
// Depends on srs_pkg for widths and step count.
module srs_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [srs_pkg::SumW-1:0]    dividend_i,
  input  logic [srs_pkg::CountW-1:0]  divisor_i,
  output logic [srs_pkg::SumW-1:0]    quotient_o,
  output logic                        done_o
);

  logic                        busy_q;
  logic                        done_q;
  logic [srs_pkg::StepW-1:0]   step_q;
  logic [srs_pkg::CountW-1:0]  rem_q;
  logic [srs_pkg::CountW-1:0]  div_q;
  logic [srs_pkg::SumW-1:0]    quo_q;
  logic [srs_pkg::CountW:0]    rem_sh;
  logic                        fits;
  logic [srs_pkg::CountW:0]    rem_sub;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    rem_sh  = {rem_q, quo_q[srs_pkg::SumW-1]};
    fits    = rem_sh >= {1'b0, div_q};
    rem_sub = rem_sh - {1'b0, div_q};
  end

  // Step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == srs_pkg::StepW'(srs_pkg::DivSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        step_q <= step_q + srs_pkg::StepW'(1);
      end
    end
  end

  // Remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? rem_sub[srs_pkg::CountW-1:0] : rem_sh[srs_pkg::CountW-1:0];
      quo_q <= {quo_q[srs_pkg::SumW-2:0], fits};
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

FILE: sv/srs_datapath.sv
// Statistics datapath: threshold registers, running counts, min/max/sum, bands,
// first alarm capture, summary registers and the average divider. Uses srs_pkg, srs_div.
module srs_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  srs_pkg::cmd_t                       cmd_i,
  output srs_pkg::status_t                    status_o,
  input  logic signed [srs_pkg::ReadingW-1:0] reading_i,
  input  logic                                cfg_we_i,
  input  logic [srs_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [srs_pkg::ValueW-1:0]          cfg_wdata_i,
  output logic [srs_pkg::CountW-1:0]          valid_total_o,
  output logic [srs_pkg::CountW-1:0]          skipped_total_o,
  output logic [srs_pkg::ValueW-1:0]          lowest_o,
  output logic [srs_pkg::ValueW-1:0]          highest_o,
  output logic [srs_pkg::ValueW-1:0]          mean_value_o,
  output logic [srs_pkg::CountW-1:0]          normal_total_o,
  output logic [srs_pkg::CountW-1:0]          warning_total_o,
  output logic [srs_pkg::CountW-1:0]          critical_total_o,
  output logic [srs_pkg::CountW-1:0]          shutdown_total_o,
  output logic [srs_pkg::CountW-1:0]          first_alarm_position_o,
  output logic [srs_pkg::ValueW-1:0]          first_alarm_value_o
);

  // Threshold registers
  logic [srs_pkg::ValueW-1:0] warn_q, crit_q, shut_q;

  // Running state
  logic [srs_pkg::CountW-1:0] pos_q, valid_q, skip_q, alarm_pos_q;
  logic [srs_pkg::ValueW-1:0] min_q, max_q, alarm_val_q;
  logic [srs_pkg::SumW-1:0]   sum_q;
  logic [srs_pkg::CountW-1:0] band_q [srs_pkg::BandNum];

  // Updated state for the accepted item
  logic [srs_pkg::CountW-1:0] pos_d, valid_d, skip_d, alarm_pos_d;
  logic [srs_pkg::ValueW-1:0] min_d, max_d, alarm_val_d;
  logic [srs_pkg::SumW-1:0]   sum_d;
  logic [srs_pkg::CountW-1:0] band_d [srs_pkg::BandNum];

  logic [srs_pkg::ValueW-1:0] r;
  logic                       neg;
  logic [srs_pkg::BandW-1:0]  band;

  // Summary registers
  logic [srs_pkg::CountW-1:0] valid_out_q, skip_out_q, alarm_pos_out_q;
  logic [srs_pkg::ValueW-1:0] min_out_q, max_out_q, alarm_val_out_q;
  logic [srs_pkg::CountW-1:0] band_out_q [srs_pkg::BandNum];

  logic [srs_pkg::SumW-1:0]   quotient;
  logic                       div_done;

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warn_q <= srs_pkg::WarningReset;
      crit_q <= srs_pkg::CriticalReset;
      shut_q <= srs_pkg::ShutdownReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        srs_pkg::RegWarning:  warn_q <= cfg_wdata_i;
        srs_pkg::RegCritical: crit_q <= cfg_wdata_i;
        srs_pkg::RegShutdown: shut_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Band of the incoming reading, tested in order
  always_comb begin
    r   = reading_i[srs_pkg::ValueW-1:0];
    neg = reading_i[srs_pkg::ReadingW-1];
    priority if (r < warn_q) band = srs_pkg::BandNormal;
    else if (r < crit_q)     band = srs_pkg::BandWarning;
    else if (r < shut_q)     band = srs_pkg::BandCritical;
    else                     band = srs_pkg::BandShutdown;
  end

  // Fold one reading into the running state
  always_comb begin
    pos_d       = srs_pkg::sat_inc(pos_q);
    valid_d     = valid_q;
    skip_d      = skip_q;
    min_d       = min_q;
    max_d       = max_q;
    sum_d       = sum_q;
    alarm_pos_d = alarm_pos_q;
    alarm_val_d = alarm_val_q;
    for (int b = 0; b < srs_pkg::BandNum; b++) begin
      band_d[b] = band_q[b];
    end
    if (neg) begin
      skip_d = srs_pkg::sat_inc(skip_q);
    end else begin
      if (valid_q == '0) begin
        min_d = r;
        max_d = r;
      end else begin
        if (r < min_q) min_d = r;
        if (r > max_q) max_d = r;
      end
      if (valid_q < srs_pkg::CountCap) begin
        sum_d   = sum_q + srs_pkg::SumW'(r);
        valid_d = valid_q + srs_pkg::CountW'(1);
      end
      band_d[band] = srs_pkg::sat_inc(band_q[band]);
      if (alarm_pos_q == '0 && r >= crit_q) begin
        alarm_pos_d = pos_d;
        alarm_val_d = r;
      end
    end
  end

  // Running state: advance per item, clear when the set closes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      valid_q     <= '0;
      skip_q      <= '0;
      min_q       <= '0;
      max_q       <= '0;
      sum_q       <= '0;
      alarm_pos_q <= '0;
      alarm_val_q <= '0;
      for (int b = 0; b < srs_pkg::BandNum; b++) begin
        band_q[b] <= '0;
      end
    end else if (cmd_i.item_accept) begin
      if (cmd_i.close_set) begin
        pos_q       <= '0;
        valid_q     <= '0;
        skip_q      <= '0;
        min_q       <= '0;
        max_q       <= '0;
        sum_q       <= '0;
        alarm_pos_q <= '0;
        alarm_val_q <= '0;
        for (int b = 0; b < srs_pkg::BandNum; b++) begin
          band_q[b] <= '0;
        end
      end else begin
        pos_q       <= pos_d;
        valid_q     <= valid_d;
        skip_q      <= skip_d;
        min_q       <= min_d;
        max_q       <= max_d;
        sum_q       <= sum_d;
        alarm_pos_q <= alarm_pos_d;
        alarm_val_q <= alarm_val_d;
        for (int b = 0; b < srs_pkg::BandNum; b++) begin
          band_q[b] <= band_d[b];
        end
      end
    end
  end

  // Capture the summary of the closing set
  always_ff @(posedge clk_i) begin
    if (cmd_i.close_set) begin
      valid_out_q     <= valid_d;
      skip_out_q      <= skip_d;
      min_out_q       <= min_d;
      max_out_q       <= max_d;
      alarm_pos_out_q <= alarm_pos_d;
      alarm_val_out_q <= alarm_val_d;
      for (int b = 0; b < srs_pkg::BandNum; b++) begin
        band_out_q[b] <= band_d[b];
      end
    end
  end

  // Average: sum over valid count
  srs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.close_set),
    .dividend_i (sum_d),
    .divisor_i  (valid_d),
    .quotient_o (quotient),
    .done_o     (div_done)
  );

  assign status_o.div_done = div_done;

  // Zero when no valid reading, clamp to the field range otherwise
  always_comb begin
    if (valid_out_q == '0) begin
      mean_value_o = '0;
    end else if (quotient[srs_pkg::SumW-1:srs_pkg::ValueW] != '0) begin
      mean_value_o = '1;
    end else begin
      mean_value_o = quotient[srs_pkg::ValueW-1:0];
    end
  end

  assign valid_total_o          = valid_out_q;
  assign skipped_total_o        = skip_out_q;
  assign lowest_o               = min_out_q;
  assign highest_o              = max_out_q;
  assign normal_total_o         = band_out_q[srs_pkg::BandNormal];
  assign warning_total_o        = band_out_q[srs_pkg::BandWarning];
  assign critical_total_o       = band_out_q[srs_pkg::BandCritical];
  assign shutdown_total_o       = band_out_q[srs_pkg::BandShutdown];
  assign first_alarm_position_o = alarm_pos_out_q;
  assign first_alarm_value_o    = alarm_val_out_q;

endmodule

FILE: sv/srs_ctrl.sv
// Controller: input acceptance, set close, divider wait and summary handshake.
// Uses srs_pkg for the command and status structs.
module srs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              last_reading_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output srs_pkg::cmd_t     cmd_o,
  input  srs_pkg::status_t  status_i
);

  typedef enum logic [1:0] {
    StAccum  = 2'b01,
    StDivide = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  // Hold input while dividing, and hold a closing item while a summary waits
  always_comb begin
    unique case (state_q)
      StAccum:  in_stall_o = last_reading_i && out_valid_q;
      StDivide: in_stall_o = 1'b1;
      default:  in_stall_o = 1'b1;
    endcase
  end

  assign accept            = in_valid_i && !in_stall_o;
  assign cmd_o.item_accept = accept;
  assign cmd_o.close_set   = accept && last_reading_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StAccum:  if (cmd_o.close_set) state_d = StDivide;
      StDivide: if (status_i.div_done) state_d = StAccum;
      default:  state_d = StAccum;
    endcase
  end

  // Summary valid: raise when the average is ready, drop when taken
  always_comb begin
    priority if (status_i.div_done) out_valid_d = 1'b1;
    else if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StAccum;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: sv/sensor_reading_statistics_unit.sv
// Top level of the sensor reading statistics unit: controller plus datapath.
// Uses srs_pkg, srs_ctrl, srs_datapath (which holds srs_div).
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------------------------
//   in       | in_valid_i / in_stall_o   | reading_i, last_reading_i
//   out      | out_valid_o / out_stall_i | valid_total_o .. first_alarm_value_o
//   config   | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// A reading that does not close its set is taken back to back unless the divider is busy.
// A closing reading starts the 26-step bit-serial divider for the average; the input
// is stalled until the divider is done, and the summary then shows on out_valid_o.
// A closing reading is also stalled while the previous summary is not yet taken.
// Reset restores thresholds 300/450/600 and clears all running statistics.
module sensor_reading_statistics_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [srs_pkg::ReadingW-1:0] reading_i,
  input  logic                                last_reading_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [srs_pkg::CountW-1:0]          valid_total_o,
  output logic [srs_pkg::CountW-1:0]          skipped_total_o,
  output logic [srs_pkg::ValueW-1:0]          lowest_o,
  output logic [srs_pkg::ValueW-1:0]          highest_o,
  output logic [srs_pkg::ValueW-1:0]          mean_value_o,
  output logic [srs_pkg::CountW-1:0]          normal_total_o,
  output logic [srs_pkg::CountW-1:0]          warning_total_o,
  output logic [srs_pkg::CountW-1:0]          critical_total_o,
  output logic [srs_pkg::CountW-1:0]          shutdown_total_o,
  output logic [srs_pkg::CountW-1:0]          first_alarm_position_o,
  output logic [srs_pkg::ValueW-1:0]          first_alarm_value_o,
  input  logic                                cfg_we_i,
  input  logic [srs_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [srs_pkg::ValueW-1:0]          cfg_wdata_i
);

  srs_pkg::cmd_t    cmd;
  srs_pkg::status_t status;

  // Sequence items and the summary handshake
  srs_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .last_reading_i (last_reading_i),
    .in_stall_o     (in_stall_o),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cmd_o          (cmd),
    .status_i       (status)
  );

  // Accumulate statistics and form the summary
  srs_datapath u_datapath (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cmd_i                  (cmd),
    .status_o               (status),
    .reading_i              (reading_i),
    .cfg_we_i               (cfg_we_i),
    .cfg_idx_i              (cfg_idx_i),
    .cfg_wdata_i            (cfg_wdata_i),
    .valid_total_o          (valid_total_o),
    .skipped_total_o        (skipped_total_o),
    .lowest_o               (lowest_o),
    .highest_o              (highest_o),
    .mean_value_o           (mean_value_o),
    .normal_total_o         (normal_total_o),
    .warning_total_o        (warning_total_o),
    .critical_total_o       (critical_total_o),
    .shutdown_total_o       (shutdown_total_o),
    .first_alarm_position_o (first_alarm_position_o),
    .first_alarm_value_o    (first_alarm_value_o)
  );

endmodule

FILE: verif/sensor_reading_statistics_unit_test.sv
`timescale 1ns / 1ps
// Testbench for sensor_reading_statistics_unit: directed and random reading sets,
// checked against a summary predictor kept in this file. Depends on srs_pkg.
module sensor_reading_statistics_unit_test;

  localparam int ClkPeriod   = 10;
  localparam int ResetCycles = 7;
  localparam int SettleCycles = 40;
  localparam int CycleLimit  = 1_000_000;
  localparam int RandomItems = 300;
  localparam int RandomPhases = 6;
  localparam logic [srs_pkg::ValueW-1:0] ValueMax = {srs_pkg::ValueW{1'b1}};

  // One summary of a closed set
  typedef struct {
    logic [srs_pkg::CountW-1:0] valid_total;
    logic [srs_pkg::CountW-1:0] skipped_total;
    logic [srs_pkg::ValueW-1:0] lowest;
    logic [srs_pkg::ValueW-1:0] highest;
    logic [srs_pkg::ValueW-1:0] mean_value;
    logic [srs_pkg::CountW-1:0] normal_total;
    logic [srs_pkg::CountW-1:0] warning_total;
    logic [srs_pkg::CountW-1:0] critical_total;
    logic [srs_pkg::CountW-1:0] shutdown_total;
    logic [srs_pkg::CountW-1:0] first_alarm_position;
    logic [srs_pkg::ValueW-1:0] first_alarm_value;
  } summary_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [srs_pkg::ReadingW-1:0]  reading_i;
  logic                          last_reading_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [srs_pkg::CountW-1:0]    valid_total_o;
  logic [srs_pkg::CountW-1:0]    skipped_total_o;
  logic [srs_pkg::ValueW-1:0]    lowest_o;
  logic [srs_pkg::ValueW-1:0]    highest_o;
  logic [srs_pkg::ValueW-1:0]    mean_value_o;
  logic [srs_pkg::CountW-1:0]    normal_total_o;
  logic [srs_pkg::CountW-1:0]    warning_total_o;
  logic [srs_pkg::CountW-1:0]    critical_total_o;
  logic [srs_pkg::CountW-1:0]    shutdown_total_o;
  logic [srs_pkg::CountW-1:0]    first_alarm_position_o;
  logic [srs_pkg::ValueW-1:0]    first_alarm_value_o;
  logic                          cfg_we_i;
  logic [srs_pkg::CfgIdxW-1:0]   cfg_idx_i;
  logic [srs_pkg::ValueW-1:0]    cfg_wdata_i;

  // Predictor copy of the thresholds and of the open set
  logic [srs_pkg::ValueW-1:0] thr_warning;
  logic [srs_pkg::ValueW-1:0] thr_critical;
  logic [srs_pkg::ValueW-1:0] thr_shutdown;
  logic [srs_pkg::CountW-1:0] set_position;
  logic [srs_pkg::CountW-1:0] set_valid;
  logic [srs_pkg::CountW-1:0] set_skipped;
  logic [srs_pkg::ValueW-1:0] set_low;
  logic [srs_pkg::ValueW-1:0] set_high;
  logic [srs_pkg::SumW-1:0]   set_sum;
  logic [srs_pkg::CountW-1:0] band_tally [srs_pkg::BandNum];
  logic [srs_pkg::CountW-1:0] alarm_pos;
  logic [srs_pkg::ValueW-1:0] alarm_val;

  summary_t expected_summaries[$];
  int       failures = 0;
  int       cycle_count = 0;
  bit       calm;

  sensor_reading_statistics_unit i_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .reading_i             (reading_i),
    .last_reading_i        (last_reading_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .valid_total_o         (valid_total_o),
    .skipped_total_o       (skipped_total_o),
    .lowest_o              (lowest_o),
    .highest_o             (highest_o),
    .mean_value_o          (mean_value_o),
    .normal_total_o        (normal_total_o),
    .warning_total_o       (warning_total_o),
    .critical_total_o      (critical_total_o),
    .shutdown_total_o      (shutdown_total_o),
    .first_alarm_position_o(first_alarm_position_o),
    .first_alarm_value_o   (first_alarm_value_o),
    .cfg_we_i              (cfg_we_i),
    .cfg_idx_i             (cfg_idx_i),
    .cfg_wdata_i           (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [srs_pkg::CountW-1:0] count_up(
    input logic [srs_pkg::CountW-1:0] c);
    return (c < srs_pkg::CountCap) ? c + srs_pkg::CountW'(1) : srs_pkg::CountCap;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (calm) return 0;
    if (k < 65) return 0;
    if (k < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Reading mix: skipped, full range, extremes, near a threshold, low values
  function automatic logic [srs_pkg::ReadingW-1:0] random_reading();
    int base;
    int v;
    case ($urandom_range(0, 9))
      0, 1: return srs_pkg::ReadingW'($urandom) | 16'h8000;
      2: return srs_pkg::ReadingW'($urandom);
      3: return $urandom_range(0, 1) ? {1'b0, ValueMax} : '0;
      4, 5: begin
        case ($urandom_range(0, 2))
          0: base = int'(thr_warning);
          1: base = int'(thr_critical);
          default: base = int'(thr_shutdown);
        endcase
        v = base + int'($urandom_range(0, 6)) - 3;
        if (v < 0) v = 0;
        if (v > int'(ValueMax)) v = int'(ValueMax);
        return srs_pkg::ReadingW'(v);
      end
      default: return srs_pkg::ReadingW'($urandom_range(0, 1000));
    endcase
  endfunction

  task automatic clear_set();
    set_position = '0;
    set_valid    = '0;
    set_skipped  = '0;
    set_low      = '0;
    set_high     = '0;
    set_sum      = '0;
    alarm_pos    = '0;
    alarm_val    = '0;
    for (int b = 0; b < srs_pkg::BandNum; b++) band_tally[b] = '0;
  endtask

  // Fold one accepted reading into the open set; queue a summary when it closes
  task automatic absorb_reading(input logic [srs_pkg::ReadingW-1:0] raw,
                                input logic closes);
    logic [srs_pkg::ValueW-1:0] r;
    logic [srs_pkg::SumW-1:0]   quotient;
    logic [srs_pkg::BandW-1:0]  band;
    summary_t                   s;
    r = raw[srs_pkg::ValueW-1:0];
    set_position = count_up(set_position);
    if (raw[srs_pkg::ReadingW-1]) begin
      set_skipped = count_up(set_skipped);
    end else begin
      if (set_valid == 0) begin
        set_low  = r;
        set_high = r;
      end
      if (r < set_low) set_low = r;
      if (r > set_high) set_high = r;
      // the sum stops growing once the valid count is capped
      if (set_valid < srs_pkg::CountCap) begin
        set_sum   = set_sum + srs_pkg::SumW'(r);
        set_valid = set_valid + srs_pkg::CountW'(1);
      end
      if (r < thr_warning) band = srs_pkg::BandNormal;
      else if (r < thr_critical) band = srs_pkg::BandWarning;
      else if (r < thr_shutdown) band = srs_pkg::BandCritical;
      else band = srs_pkg::BandShutdown;
      band_tally[band] = count_up(band_tally[band]);
      if (alarm_pos == 0 && r >= thr_critical) begin
        alarm_pos = set_position;
        alarm_val = r;
      end
    end
    if (closes) begin
      quotient = '0;
      if (set_valid != 0) begin
        quotient = set_sum / srs_pkg::SumW'(set_valid);
        if (quotient > srs_pkg::SumW'(ValueMax)) quotient = srs_pkg::SumW'(ValueMax);
      end
      s.valid_total          = set_valid;
      s.skipped_total        = set_skipped;
      s.lowest               = set_low;
      s.highest              = set_high;
      s.mean_value           = quotient[srs_pkg::ValueW-1:0];
      s.normal_total         = band_tally[srs_pkg::BandNormal];
      s.warning_total        = band_tally[srs_pkg::BandWarning];
      s.critical_total       = band_tally[srs_pkg::BandCritical];
      s.shutdown_total       = band_tally[srs_pkg::BandShutdown];
      s.first_alarm_position = alarm_pos;
      s.first_alarm_value    = alarm_val;
      expected_summaries.push_back(s);
      clear_set();
    end
  endtask

  // Offer one item, hold it until taken, then predict; valid stays high on return
  task automatic send_reading(input logic [srs_pkg::ReadingW-1:0] raw, input logic closes);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    reading_i      <= raw;
    last_reading_i <= closes;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    absorb_reading(raw, closes);
  endtask

  // Drop valid, wait for every summary, then let the divider settle
  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    while (expected_summaries.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write all three thresholds on back-to-back cycles
  task automatic write_thresholds(input logic [srs_pkg::ValueW-1:0] w,
                                  input logic [srs_pkg::ValueW-1:0] c,
                                  input logic [srs_pkg::ValueW-1:0] s);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= srs_pkg::RegWarning;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_idx_i   <= srs_pkg::RegCritical;
    cfg_wdata_i <= c;
    @(posedge clk_i);
    cfg_idx_i   <= srs_pkg::RegShutdown;
    cfg_wdata_i <= s;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    thr_warning  = w;
    thr_critical = c;
    thr_shutdown = s;
  endtask

  // Receiver: random stall runs, none while calm
  initial begin
    int stall_run;
    stall_run = 0;
    forever begin
      @(posedge clk_i);
      if (calm) begin
        out_stall_i <= 1'b0;
      end else if (stall_run == 0) begin
        out_stall_i <= ($urandom_range(0, 99) < 35);
        stall_run = pick_gap() + 1;
      end else begin
        stall_run--;
      end
    end
  end

  task automatic check_field(input string name, input logic [srs_pkg::ReadingW-1:0] want,
                             input logic [srs_pkg::ReadingW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  // Compare each taken summary with the oldest one predicted
  always @(posedge clk_i) begin : check_summary
    summary_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_summaries.size() == 0) begin
        $error("summary item with none expected");
        failures++;
      end else begin
        want = expected_summaries.pop_front();
        check_field("valid_total", want.valid_total, valid_total_o);
        check_field("skipped_total", want.skipped_total, skipped_total_o);
        check_field("lowest", want.lowest, lowest_o);
        check_field("highest", want.highest, highest_o);
        check_field("mean_value", want.mean_value, mean_value_o);
        check_field("normal_total", want.normal_total, normal_total_o);
        check_field("warning_total", want.warning_total, warning_total_o);
        check_field("critical_total", want.critical_total, critical_total_o);
        check_field("shutdown_total", want.shutdown_total, shutdown_total_o);
        check_field("first_alarm_position", want.first_alarm_position,
                    first_alarm_position_o);
        check_field("first_alarm_value", want.first_alarm_value, first_alarm_value_o);
      end
    end
  end

  // Reset thresholds: band edges, extremes, sets with no valid reading, one-item sets
  task automatic test_band_edges();
    send_reading(16'd0, 1'b0);
    send_reading(16'd299, 1'b0);
    send_reading(16'd300, 1'b0);
    send_reading(16'd449, 1'b0);
    send_reading(16'd450, 1'b0);
    send_reading(16'd599, 1'b0);
    send_reading(16'd600, 1'b0);
    send_reading(16'h7FFF, 1'b0);
    send_reading(16'hFFFF, 1'b0);
    send_reading(16'h8000, 1'b0);
    send_reading(16'd100, 1'b1);
    send_reading(16'hFFFB, 1'b0);
    send_reading(16'h8000, 1'b1);
    send_reading(16'h7FFF, 1'b1);
    send_reading(16'd0, 1'b1);
    wait_until_drained();
  endtask

  // Thresholds at zero, at the top, and out of order
  task automatic test_threshold_extremes();
    write_thresholds('0, '0, '0);
    send_reading(16'd0, 1'b0);
    send_reading(16'h8000, 1'b0);
    send_reading(16'h7FFF, 1'b0);
    send_reading(16'd5, 1'b1);
    wait_until_drained();
    write_thresholds(ValueMax, ValueMax, ValueMax);
    send_reading(16'h7FFE, 1'b0);
    send_reading(16'h7FFF, 1'b0);
    send_reading(16'hFFFF, 1'b1);
    wait_until_drained();
    write_thresholds(15'd500, 15'd200, 15'd100);
    send_reading(16'd150, 1'b0);
    send_reading(16'd99, 1'b0);
    send_reading(16'd600, 1'b0);
    send_reading(16'd200, 1'b1);
    wait_until_drained();
  endtask

  // Saturate the counts: alarm and sum past the cap, then a long run of skips
  task automatic test_saturation();
    int n;
    n = int'(srs_pkg::CountCap) + 2;
    write_thresholds(srs_pkg::WarningReset, srs_pkg::CriticalReset, srs_pkg::ShutdownReset);
    for (int i = 0; i < n; i++) begin
      send_reading(srs_pkg::ReadingW'($urandom_range(0, 299)), 1'b0);
    end
    send_reading(16'd500, 1'b0);
    send_reading(16'h7FFF, 1'b0);
    send_reading(16'd10, 1'b1);
    for (int i = 0; i < n; i++) send_reading(srs_pkg::ReadingW'($urandom) | 16'h8000, 1'b0);
    send_reading(16'hFFFF, 1'b1);
    wait_until_drained();
  endtask

  // Random sets over several threshold settings, one phase without idling
  task automatic test_random_sets();
    logic [srs_pkg::ValueW-1:0] t0, t1, t2, tmp;
    int sent;
    int len;
    for (int p = 0; p < RandomPhases; p++) begin
      t0 = srs_pkg::ValueW'($urandom);
      t1 = srs_pkg::ValueW'($urandom);
      t2 = srs_pkg::ValueW'($urandom);
      case ($urandom_range(0, 3))
        0: begin
          t0 = srs_pkg::WarningReset;
          t1 = srs_pkg::CriticalReset;
          t2 = srs_pkg::ShutdownReset;
        end
        1, 3: begin
          if ($urandom_range(0, 1)) begin
            t0 = srs_pkg::ValueW'($urandom_range(0, 700));
            t1 = srs_pkg::ValueW'($urandom_range(0, 700));
            t2 = srs_pkg::ValueW'($urandom_range(0, 700));
          end
          // order them so all four bands are reachable
          if (t0 > t1) begin tmp = t0; t0 = t1; t1 = tmp; end
          if (t1 > t2) begin tmp = t1; t1 = t2; t2 = tmp; end
          if (t0 > t1) begin tmp = t0; t0 = t1; t1 = tmp; end
        end
        default: ;
      endcase
      write_thresholds(t0, t1, t2);
      calm = (p == 2);
      sent = 0;
      while (sent < RandomItems / RandomPhases) begin
        case ($urandom_range(0, 19))
          0: len = $urandom_range(30, 60);
          1, 2, 3: len = $urandom_range(13, 30);
          default: len = $urandom_range(1, 12);
        endcase
        for (int i = 0; i < len; i++) send_reading(random_reading(), i == len - 1);
        sent += len;
      end
      wait_until_drained();
      calm = 1'b0;
    end
  endtask

  initial begin
    calm           = 1'b0;
    thr_warning    = srs_pkg::WarningReset;
    thr_critical   = srs_pkg::CriticalReset;
    thr_shutdown   = srs_pkg::ShutdownReset;
    clear_set();
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    reading_i      <= '0;
    last_reading_i <= 1'b0;
    out_stall_i    <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= srs_pkg::RegWarning;
    cfg_wdata_i    <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_band_edges();
    test_threshold_extremes();
    test_saturation();
    test_random_sets();

    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/srs_pkg.sv
sv/srs_div.sv
sv/srs_datapath.sv
sv/srs_ctrl.sv
sv/sensor_reading_statistics_unit.sv
verif/sensor_reading_statistics_unit_test.sv
